>>> sv/lift_hall_call_queue_store_assert.svh
// Assertion macros for the hall-call queue store
`ifndef LIFT_HALL_CALL_QUEUE_STORE_ASSERT_SVH
`define LIFT_HALL_CALL_QUEUE_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LHCQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LHCQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LHCQ_ASSERT(label, clk, rst, prop, msg)
`define LHCQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> sv/lhcq_pkg.sv
package lhcq_pkg;
   localparam int MaxFloors  = 16;
   localparam int QueueDepth = 16;
   localparam int FloorW = $clog2(MaxFloors);
   localparam int SlotW  = $clog2(QueueDepth);
   localparam int LenW   = $clog2(QueueDepth + 1);
   localparam int AddrW  = FloorW + SlotW;
   localparam logic [4:0] NoneCode  = 5'd16;
   localparam logic [4:0] ResultMax = 5'd16;

   localparam logic [1:0] OpAdd       = 2'd0;
   localparam logic [1:0] OpBoardUp   = 2'd1;
   localparam logic [1:0] OpBoardDown = 2'd2;
   localparam logic [1:0] OpQuery     = 2'd3;

   localparam logic [1:0] StatusOk   = 2'd0;
   localparam logic [1:0] StatusFull = 2'd1;
   localparam logic [1:0] StatusBad  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] floor;
      logic [3:0] dest;
      logic [4:0] capacity;
      logic [3:0] lift_pos;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       rider_valid;
      logic [3:0] rider_dest;
      logic       last;
      logic       all_empty;
      logic [4:0] down_above_floor;
      logic [4:0] up_above_floor;
      logic [4:0] down_below_floor;
      logic [4:0] up_below_floor;
   } rsp_type;

   typedef struct packed {
      logic             we;
      logic [AddrW-1:0] waddr;
      logic [3:0]       wdata;
      logic [AddrW-1:0] raddr;
   } ram_ctl_type;
endpackage

>>> sv/lhcq_dest_ram.sv
module lhcq_dest_ram (
   input  logic                 clock,
   input  lhcq_pkg::ram_ctl_type ctl,
   output logic [3:0]           rd_data
);
   logic [3:0] mem [0:(1 << lhcq_pkg::AddrW)-1];

   // write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rd_data <= mem[ctl.raddr];
   end
endmodule

>>> sv/lift_hall_call_queue_store.sv
// Add and query requests: result on the ports the cycle after the accepting edge;
// the next request may be accepted at the very next edge.
// Board requests: busy while walking the floor's queue through the destination memory
// (one entry per cycle), then while emitting the results (at least one result).
// Results are single-cycle strobes; the receiver cannot stall them.
// Synchronous reset empties all queues and sets floor_count to 16; no clearing pass.
`include "lift_hall_call_queue_store_assert.svh"
module lift_hall_call_queue_store (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lhcq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output lhcq_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data
);
   localparam int NF = lhcq_pkg::MaxFloors;
   localparam int LW = lhcq_pkg::LenW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] floor_count_ff;
   logic [4:0] n_floors;
   logic [LW-1:0] len_ff [NF], len_in [NF];
   logic [LW-1:0] up_ff [NF], up_in [NF];
   logic [LW-1:0] dn_ff [NF], dn_in [NF];
   logic [3:0] fl_ff, fl_in;
   logic dir_up_ff, dir_up_in;
   logic [4:0] limit_ff, limit_in;
   logic [LW-1:0] scan_len_ff, scan_len_in;
   logic [LW-1:0] rd_k_ff, rd_k_in;
   logic [LW-1:0] kept_ff, kept_in;
   logic [4:0] taken_ff, taken_in;
   logic pend_ff, pend_in;
   logic [3:0] em_ff, em_in;
   logic [3:0] rider_ff [lhcq_pkg::QueueDepth];
   logic rsp_strobe_ff, rsp_strobe_in;
   lhcq_pkg::rsp_type rsp_ff, rsp_in;
   lhcq_pkg::ram_ctl_type ram_ctl;
   logic [3:0] rd_data;
   logic accept;
   logic is_match;
   logic take;
   logic [4:0] t_da, t_ua, t_db, t_ub;

   lhcq_dest_ram u_ram (.clock(clock), .ctl(ram_ctl), .rd_data(rd_data));

   assign n_floors = (floor_count_ff == 5'd0) ? 5'd1 :
                     (floor_count_ff > 5'(NF)) ? 5'(NF) : floor_count_ff;
   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;
   assign is_match = dir_up_ff ? (rd_data > fl_ff) : (rd_data < fl_ff);
   assign take = pend_ff && is_match && (taken_ff < limit_ff);

   function automatic logic all_empty_f(input logic [LW-1:0] lens [NF], input logic [4:0] n);
      logic e;
      e = 1'b1;
      for (int f = 0; f < NF; f++) begin
         if (5'(f) < n && lens[f] != '0) e = 1'b0;
      end
      return e;
   endfunction

   // search SCAN targets from per-floor direction counts
   always_comb begin
      t_da = lhcq_pkg::NoneCode;
      t_ua = lhcq_pkg::NoneCode;
      t_db = lhcq_pkg::NoneCode;
      t_ub = lhcq_pkg::NoneCode;
      for (int f = 0; f < NF; f++) begin
         if (5'(f) < n_floors) begin
            if (5'(f) > {1'b0, req_data.lift_pos}) begin
               if (dn_ff[f] != '0) t_da = 5'(f);
               if (t_ua == lhcq_pkg::NoneCode && up_ff[f] != '0) t_ua = 5'(f);
            end else if (5'(f) < {1'b0, req_data.lift_pos}) begin
               if (dn_ff[f] != '0) t_db = 5'(f);
               if (t_ub == lhcq_pkg::NoneCode && up_ff[f] != '0) t_ub = 5'(f);
            end
         end
      end
   end

   // sequence requests: single-shot ops, queue walk, rider emission
   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      up_in = up_ff;
      dn_in = dn_ff;
      fl_in = fl_ff;
      dir_up_in = dir_up_ff;
      limit_in = limit_ff;
      scan_len_in = scan_len_ff;
      rd_k_in = rd_k_ff;
      kept_in = kept_ff;
      taken_in = taken_ff;
      pend_in = 1'b0;
      em_in = em_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      ram_ctl.we = 1'b0;
      ram_ctl.waddr = {fl_ff, kept_ff[lhcq_pkg::SlotW-1:0]};
      ram_ctl.wdata = rd_data;
      ram_ctl.raddr = {fl_ff, rd_k_ff[lhcq_pkg::SlotW-1:0]};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.rider_valid = 1'b0;
               rsp_in.rider_dest = 4'd0;
               rsp_in.last = 1'b1;
               rsp_in.status = lhcq_pkg::StatusOk;
               rsp_in.down_above_floor = lhcq_pkg::NoneCode;
               rsp_in.up_above_floor = lhcq_pkg::NoneCode;
               rsp_in.down_below_floor = lhcq_pkg::NoneCode;
               rsp_in.up_below_floor = lhcq_pkg::NoneCode;
               case (req_data.op)
                  lhcq_pkg::OpAdd: begin
                     rsp_strobe_in = 1'b1;
                     if ({1'b0, req_data.floor} >= n_floors ||
                         {1'b0, req_data.dest} >= n_floors ||
                         req_data.dest == req_data.floor) begin
                        rsp_in.status = lhcq_pkg::StatusBad;
                     end else if (len_ff[req_data.floor] >= LW'(lhcq_pkg::QueueDepth)) begin
                        rsp_in.status = lhcq_pkg::StatusFull;
                     end else begin
                        ram_ctl.we = 1'b1;
                        ram_ctl.waddr = {req_data.floor,
                                         len_ff[req_data.floor][lhcq_pkg::SlotW-1:0]};
                        ram_ctl.wdata = req_data.dest;
                        len_in[req_data.floor] = len_ff[req_data.floor] + 1'b1;
                        if (req_data.dest > req_data.floor)
                           up_in[req_data.floor] = up_ff[req_data.floor] + 1'b1;
                        else
                           dn_in[req_data.floor] = dn_ff[req_data.floor] + 1'b1;
                     end
                     rsp_in.all_empty = all_empty_f(len_in, n_floors);
                  end
                  lhcq_pkg::OpQuery: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.all_empty = all_empty_f(len_ff, n_floors);
                     rsp_in.down_above_floor = t_da;
                     rsp_in.up_above_floor = t_ua;
                     rsp_in.down_below_floor = t_db;
                     rsp_in.up_below_floor = t_ub;
                  end
                  default: begin
                     if ({1'b0, req_data.floor} >= n_floors) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = lhcq_pkg::StatusBad;
                        rsp_in.all_empty = all_empty_f(len_ff, n_floors);
                     end else begin
                        // start walk: issue read of slot 0
                        fl_in = req_data.floor;
                        dir_up_in = (req_data.op == lhcq_pkg::OpBoardUp);
                        limit_in = (req_data.capacity < lhcq_pkg::ResultMax) ?
                                   req_data.capacity : lhcq_pkg::ResultMax;
                        scan_len_in = len_ff[req_data.floor];
                        ram_ctl.raddr = {req_data.floor, {lhcq_pkg::SlotW{1'b0}}};
                        pend_in = (len_ff[req_data.floor] != '0);
                        rd_k_in = LW'(1);
                        kept_in = '0;
                        taken_in = 5'd0;
                        state_in = ST_SCAN;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // advance the read pointer
            if (rd_k_ff < scan_len_ff) begin
               pend_in = 1'b1;
               rd_k_in = rd_k_ff + 1'b1;
            end
            if (pend_ff) begin
               if (take) begin
                  taken_in = taken_ff + 5'd1;
                  if (dir_up_ff) up_in[fl_ff] = up_ff[fl_ff] - 1'b1;
                  else dn_in[fl_ff] = dn_ff[fl_ff] - 1'b1;
               end else begin
                  // compact: keep entry at next kept slot
                  ram_ctl.we = 1'b1;
                  kept_in = kept_ff + 1'b1;
               end
            end else begin
               len_in[fl_ff] = kept_ff;
               em_in = 4'd0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = lhcq_pkg::StatusOk;
            rsp_in.all_empty = all_empty_f(len_ff, n_floors);
            rsp_in.down_above_floor = lhcq_pkg::NoneCode;
            rsp_in.up_above_floor = lhcq_pkg::NoneCode;
            rsp_in.down_below_floor = lhcq_pkg::NoneCode;
            rsp_in.up_below_floor = lhcq_pkg::NoneCode;
            if (taken_ff == 5'd0) begin
               rsp_in.rider_valid = 1'b0;
               rsp_in.rider_dest = 4'd0;
               rsp_in.last = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rsp_in.rider_valid = 1'b1;
               rsp_in.rider_dest = rider_ff[em_ff];
               rsp_in.last = ({1'b0, em_ff} == taken_ff - 5'd1);
               em_in = em_ff + 4'd1;
               if (rsp_in.last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold boarded riders
   always_ff @(posedge clock) begin
      if (state_ff == ST_SCAN && take) begin
         rider_ff[taken_ff[3:0]] <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         floor_count_ff <= 5'd16;
         rsp_strobe_ff <= 1'b0;
         pend_ff <= 1'b0;
         for (int f = 0; f < NF; f++) begin
            len_ff[f] <= '0;
            up_ff[f] <= '0;
            dn_ff[f] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) floor_count_ff <= csr_wr_data;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff <= pend_in;
         len_ff <= len_in;
         up_ff <= up_in;
         dn_ff <= dn_in;
      end
   end

   always_ff @(posedge clock) begin
      fl_ff <= fl_in;
      dir_up_ff <= dir_up_in;
      limit_ff <= limit_in;
      scan_len_ff <= scan_len_in;
      rd_k_ff <= rd_k_in;
      kept_ff <= kept_in;
      taken_ff <= taken_in;
      em_ff <= em_in;
      rsp_ff <= rsp_in;
   end

   `LHCQ_ASSERT(a_board_goes_busy, clock, reset, accept && req_data.op != lhcq_pkg::OpAdd && req_data.op != lhcq_pkg::OpQuery && {1'b0, req_data.floor} < n_floors |=> busy, "board request did not start walk")
   `LHCQ_ASSERT(a_riders_back_to_back, clock, reset, rsp_strobe && !rsp_data.last |=> rsp_strobe, "gap inside rider burst")
   `LHCQ_ASSERT(a_taken_in_limit, clock, reset, state_ff == ST_SCAN |-> taken_ff <= limit_ff, "boarded beyond capacity")
   `LHCQ_ASSERT_ALWAYS(a_state_onehot, clock, reset || $onehot(state_ff), "sequencer state not one-hot")
endmodule
